// ===== src/fvts_pkg.sv =====
// ----------------------------------------------------------------------------
// fvts_pkg: shared types and constants
// Register codes, window record, queue status and back-end state encoding
// for the four-voice tone and noise synthesizer.
// ----------------------------------------------------------------------------
package fvts_pkg;

	localparam int VOICES      = 4;
	localparam int NOISE_VOICE = 3;
	localparam int SUM_W       = 22;
	localparam int TICKS_W     = 17;
	localparam int PHASE_W     = 33;
	localparam int DIV_STEPS   = SUM_W;
	localparam int CNT_W       = $clog2(DIV_STEPS);

	// register indexes on paddr[3:2]
	localparam logic [1:0] REG_PERIOD = 2'd0;
	localparam logic [1:0] REG_TAPS   = 2'd1;
	localparam logic [1:0] REG_SEED   = 2'd2;

	localparam logic [15:0] TAPS_RESET = 16'hB400;
	localparam logic [15:0] SEED_RESET = 16'h0001;
	localparam logic [PHASE_W-1:0] ONE_TICK = PHASE_W'(33'h1_0000);
	localparam logic [7:0] CENTER = 8'd128;
	localparam logic [7:0] RELOAD_BASE = 8'd128;

	typedef struct packed {
		logic [31:0] period;
		logic [15:0] taps;
		logic        seed_load;
		logic [15:0] seed_value;
	} cfg_t;

	typedef struct packed {
		logic [SUM_W-1:0]   sum;
		logic [TICKS_W-1:0] ticks;
	} win_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_FIN
	} back_state_t;

endpackage

// ===== src/fvts_tick_if.sv =====
// ----------------------------------------------------------------------------
// fvts_tick_if: chip tick channel
// Carries the four voice control bytes and the master volume of one tick.
// ----------------------------------------------------------------------------
interface fvts_tick_if;
	logic       valid;
	logic       ready;
	logic [7:0] bass_control;
	logic [7:0] alto_control;
	logic [7:0] soprano_control;
	logic [7:0] noise_control;
	logic [3:0] volume;

	modport source (output valid, bass_control, alto_control, soprano_control,
		noise_control, volume, input ready);
	modport sink (input valid, bass_control, alto_control, soprano_control,
		noise_control, volume, output ready);
endinterface

// ===== src/fvts_sample_if.sv =====
// ----------------------------------------------------------------------------
// fvts_sample_if: audio sample channel
// Carries one unsigned 8-bit sample centered at 128.
// ----------------------------------------------------------------------------
interface fvts_sample_if;
	logic       valid;
	logic       ready;
	logic [7:0] sample;

	modport source (output valid, sample, input ready);
	modport sink (input valid, sample, output ready);
endinterface

// ===== src/fvts_regs.sv =====
// ----------------------------------------------------------------------------
// fvts_regs: configuration registers
// APB register file for sample period, noise taps and noise seed.
// ----------------------------------------------------------------------------
module fvts_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output fvts_pkg::cfg_t      cfg
);

	logic [31:0] period_q;
	logic [15:0] taps_q;
	logic [15:0] seed_q;
	logic        wr;
	logic [1:0]  idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			taps_q   <= fvts_pkg::TAPS_RESET;
			seed_q   <= fvts_pkg::SEED_RESET;
		end else if (wr) begin
			unique case (idx)
				fvts_pkg::REG_PERIOD: period_q <= pwdata;
				fvts_pkg::REG_TAPS:   taps_q   <= pwdata[15:0];
				fvts_pkg::REG_SEED:   seed_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			fvts_pkg::REG_PERIOD: prdata = period_q;
			fvts_pkg::REG_TAPS:   prdata = {16'd0, taps_q};
			fvts_pkg::REG_SEED:   prdata = {16'd0, seed_q};
			default:              prdata = '0;
		endcase
	end

	// seed write reloads the noise register on the same edge
	assign cfg.period     = period_q;
	assign cfg.taps       = taps_q;
	assign cfg.seed_load  = wr && (idx == fvts_pkg::REG_SEED);
	assign cfg.seed_value = pwdata[15:0];

endmodule

// ===== src/fvts_front.sv =====
// ----------------------------------------------------------------------------
// fvts_front: voice engine and window accumulator
// Takes one chip tick per cycle while the queue is not full, clocks the four
// voices, accumulates the volume-scaled mix and posts a window record when
// the phase reaches or passes the period.
module fvts_front #(
	parameter int BASS_DIVIDE    = 128,
	parameter int ALTO_DIVIDE    = 64,
	parameter int SOPRANO_DIVIDE = 32,
	parameter int NOISE_DIVIDE   = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	fvts_tick_if.sink          ticks,
	input  fvts_pkg::cfg_t     cfg,
	input  fvts_pkg::q_stat_t  q_stat,
	output logic               push,
	output fvts_pkg::win_t     push_win
);

	localparam logic [7:0] DIVIDE [fvts_pkg::VOICES] = '{
		8'(BASS_DIVIDE), 8'(ALTO_DIVIDE), 8'(SOPRANO_DIVIDE), 8'(NOISE_DIVIDE)
	};

	logic [7:0]  pre_q [fvts_pkg::VOICES];
	logic [7:0]  per_q [fvts_pkg::VOICES];
	logic [fvts_pkg::VOICES-1:0] bit_q;
	logic [15:0] shift_q;
	logic [fvts_pkg::SUM_W-1:0]   sum_q;
	logic [fvts_pkg::TICKS_W-1:0] ticks_q;
	logic [fvts_pkg::PHASE_W-1:0] phase_q;

	logic [7:0]  pre_d [fvts_pkg::VOICES];
	logic [7:0]  per_d [fvts_pkg::VOICES];
	logic [fvts_pkg::VOICES-1:0] bit_d;
	logic [15:0] shift_d;
	logic [15:0] lfsr_next;
	logic [7:0]  ctl [fvts_pkg::VOICES];
	logic [2:0]  mix;
	logic [6:0]  level;
	logic [fvts_pkg::SUM_W-1:0]   sum_n;
	logic [fvts_pkg::TICKS_W-1:0] ticks_n;
	logic [fvts_pkg::PHASE_W-1:0] phase_n;
	logic        win_end;
	logic        step;

	assign ticks.ready = !q_stat.full;
	assign step = ticks.valid && ticks.ready && (cfg.period != '0);

	assign ctl[0] = ticks.bass_control;
	assign ctl[1] = ticks.alto_control;
	assign ctl[2] = ticks.soprano_control;
	assign ctl[3] = ticks.noise_control;

	assign lfsr_next = {1'b0, shift_q[15:1]} ^ (shift_q[0] ? cfg.taps : 16'd0);

	always_comb begin
		logic [7:0] pre_dec;
		pre_d   = pre_q;
		per_d   = per_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		for (int v = 0; v < fvts_pkg::VOICES; v++) begin
			pre_dec = pre_q[v] - 8'd1;
			if (pre_dec != 8'd0) begin
				pre_d[v] = pre_dec;
			end else begin
				pre_d[v] = DIVIDE[v];
				if (!ctl[v][7]) begin
					bit_d[v] = 1'b0;
					per_d[v] = 8'd0;
				end else if (per_q[v] != 8'd0) begin
					per_d[v] = per_q[v] - 8'd1;
				end else begin
					per_d[v] = fvts_pkg::RELOAD_BASE - {1'b0, ctl[v][6:0]};
					if (v == fvts_pkg::NOISE_VOICE) begin
						shift_d  = lfsr_next;
						bit_d[v] = lfsr_next[0];
					end else begin
						bit_d[v] = !bit_q[v];
					end
				end
			end
		end
	end

	assign mix     = 3'(bit_d[0]) + 3'(bit_d[1]) + 3'(bit_d[2]) + 3'(bit_d[3]);
	assign level   = mix * ticks.volume;
	assign sum_n   = sum_q + fvts_pkg::SUM_W'(level);
	assign ticks_n = ticks_q + fvts_pkg::TICKS_W'(1);
	assign phase_n = phase_q + fvts_pkg::ONE_TICK;
	assign win_end = phase_n >= {1'b0, cfg.period};

	assign push           = step && win_end;
	assign push_win.sum   = sum_n;
	assign push_win.ticks = ticks_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < fvts_pkg::VOICES; v++) begin
				pre_q[v] <= DIVIDE[v];
				per_q[v] <= 8'd0;
			end
			bit_q   <= '0;
			shift_q <= fvts_pkg::SEED_RESET;
			sum_q   <= '0;
			ticks_q <= '0;
			phase_q <= '0;
		end else if (cfg.seed_load) begin
			shift_q <= cfg.seed_value;
		end else if (step) begin
			pre_q   <= pre_d;
			per_q   <= per_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			if (win_end) begin
				// close the window: hand the totals over, restart the sums
				sum_q   <= '0;
				ticks_q <= '0;
				phase_q <= phase_n - {1'b0, cfg.period};
			end else begin
				sum_q   <= sum_n;
				ticks_q <= ticks_n;
				phase_q <= phase_n;
			end
		end
	end

endmodule

// ===== src/fvts_queue.sv =====
// ----------------------------------------------------------------------------
// fvts_queue: window record queue
// Small register FIFO between the voice engine and the averaging divider.
// ----------------------------------------------------------------------------
module fvts_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  fvts_pkg::win_t     push_win,
	input  logic               pop,
	output fvts_pkg::win_t     pop_win,
	output fvts_pkg::q_stat_t  q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	fvts_pkg::win_t    mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign q_stat.full      = count_q == CNT_W'(DEPTH);
	assign q_stat.not_empty = count_q != '0;
	assign do_push = push && !q_stat.full;
	assign do_pop  = pop && q_stat.not_empty;
	assign pop_win = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_win;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/fvts_back.sv =====
// ----------------------------------------------------------------------------
// fvts_back: window averager and sample output
// Restoring divider, one quotient bit per cycle, then 128 + 2 * average
// into the output register.
// ----------------------------------------------------------------------------
module fvts_back (
	input  logic               clk,
	input  logic               arst_n,
	input  fvts_pkg::q_stat_t  q_stat,
	input  fvts_pkg::win_t     pop_win,
	output logic               pop,
	fvts_sample_if.source      samples
);

	fvts_pkg::back_state_t state_q;
	fvts_pkg::back_state_t state_d;

	logic [fvts_pkg::SUM_W-1:0]   num_q;
	logic [fvts_pkg::SUM_W-1:0]   quo_q;
	logic [fvts_pkg::TICKS_W-1:0] den_q;
	logic [fvts_pkg::TICKS_W-1:0] rem_q;
	logic [fvts_pkg::CNT_W-1:0]   cnt_q;
	logic                         den_zero_q;
	logic                         valid_q;
	logic [7:0]                   sample_q;

	logic [fvts_pkg::TICKS_W:0]   rem_sh;
	logic                         ge;
	logic                         div_step;
	logic                         load_out;
	logic                         out_free;
	logic                         last_step;
	logic [6:0]                   avg_lo;

	assign out_free  = !valid_q || samples.ready;
	assign last_step = cnt_q == fvts_pkg::CNT_W'(fvts_pkg::DIV_STEPS - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fvts_pkg::BK_IDLE: if (q_stat.not_empty) state_d = fvts_pkg::BK_DIV;
			fvts_pkg::BK_DIV:  if (last_step) state_d = fvts_pkg::BK_FIN;
			fvts_pkg::BK_FIN:  if (out_free) state_d = fvts_pkg::BK_IDLE;
			default:           state_d = fvts_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		div_step = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			fvts_pkg::BK_IDLE: pop      = q_stat.not_empty;
			fvts_pkg::BK_DIV:  div_step = 1'b1;
			fvts_pkg::BK_FIN:  load_out = out_free;
			default: ;
		endcase
	end

	assign rem_sh = {rem_q, num_q[fvts_pkg::SUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	// only the low bits of the average reach the 8-bit sample
	assign avg_lo = den_zero_q ? 7'd0 : quo_q[6:0];

	always_ff @(posedge clk) begin
		if (pop) begin
			num_q      <= pop_win.sum;
			den_q      <= pop_win.ticks;
			den_zero_q <= pop_win.ticks == '0;
			rem_q      <= '0;
			quo_q      <= '0;
		end else if (div_step) begin
			num_q <= {num_q[fvts_pkg::SUM_W-2:0], 1'b0};
			quo_q <= {quo_q[fvts_pkg::SUM_W-2:0], ge};
			rem_q <= ge ? fvts_pkg::TICKS_W'(rem_sh - {1'b0, den_q})
			            : rem_sh[fvts_pkg::TICKS_W-1:0];
		end
		if (load_out) begin
			sample_q <= fvts_pkg::CENTER + {avg_lo, 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fvts_pkg::BK_IDLE;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				cnt_q <= '0;
			end else if (div_step) begin
				cnt_q <= cnt_q + fvts_pkg::CNT_W'(1);
			end
			if (load_out) begin
				valid_q <= 1'b1;
			end else if (samples.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign samples.valid  = valid_q;
	assign samples.sample = sample_q;

endmodule

// ===== src/four_voice_tone_noise_synth.sv =====
// ----------------------------------------------------------------------------
// four_voice_tone_noise_synth: three square-wave voices and one noise voice
// Channel   Role    Payload
// ticks     sink    bass/alto/soprano/noise control bytes, 4-bit volume
// samples   source  8-bit sample centered at 128
// APB       slave   sample_period_fp @0x0, noise_taps @0x4, noise_seed @0x8
//
// The voice engine takes one tick per cycle while the window queue has room.
// Each closed window passes the averaging divider through load, 22 quotient
// bits and output; the four-entry queue absorbs windows that close meanwhile.
// A tick taken while the period register is zero changes nothing.
// Reset is asynchronous and needs no clearing pass; ticks stall only on a
// full queue, and a held sample stalls only the divider.
// ----------------------------------------------------------------------------
module four_voice_tone_noise_synth #(
	parameter int BASS_DIVIDE    = 128,
	parameter int ALTO_DIVIDE    = 64,
	parameter int SOPRANO_DIVIDE = 32,
	parameter int NOISE_DIVIDE   = 32,
	parameter int QUEUE_DEPTH    = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	fvts_tick_if.sink    ticks,
	fvts_sample_if.source samples,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	fvts_pkg::cfg_t    cfg;
	fvts_pkg::q_stat_t q_stat;
	fvts_pkg::win_t    push_win;
	fvts_pkg::win_t    pop_win;
	logic              push;
	logic              pop;

	fvts_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fvts_front #(
		.BASS_DIVIDE    (BASS_DIVIDE),
		.ALTO_DIVIDE    (ALTO_DIVIDE),
		.SOPRANO_DIVIDE (SOPRANO_DIVIDE),
		.NOISE_DIVIDE   (NOISE_DIVIDE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.ticks    (ticks),
		.cfg      (cfg),
		.q_stat   (q_stat),
		.push     (push),
		.push_win (push_win)
	);

	fvts_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_win (push_win),
		.pop      (pop),
		.pop_win  (pop_win),
		.q_stat   (q_stat)
	);

	fvts_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.pop_win (pop_win),
		.pop     (pop),
		.samples (samples)
	);

endmodule

// ===== src/fvts_checker.sv =====
// ----------------------------------------------------------------------------
// fvts_checker: port-level checks
// Watches the sample channel and the APB port of the synthesizer.
// ----------------------------------------------------------------------------
module fvts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_sample,
	input logic        psel,
	input logic        pwrite,
	input logic [3:0]  paddr,
	input logic [31:0] prdata,
	input logic        pready
);

	// hold a stalled sample
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample))
		else $error("stalled sample changed or dropped");

	// 128 plus twice the average is always even
	a_sample_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !out_sample[0])
		else $error("odd sample value");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

	// unmapped register reads as zero
	a_unmapped_read: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && (paddr[3:2] == 2'd3) |-> prdata == 32'd0)
		else $error("unmapped register read nonzero");

endmodule

bind four_voice_tone_noise_synth fvts_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (samples.valid),
	.out_ready  (samples.ready),
	.out_sample (samples.sample),
	.psel       (psel),
	.pwrite     (pwrite),
	.paddr      (paddr),
	.prdata     (prdata),
	.pready     (pready)
);
